// ===== hw/rtl/hsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg: shared types and constants of the hsl to rgb converter
// Field widths, fixed-point scaling constants, the channel select type,
// the pipeline enable bundle and the hue ramp function.
// ----------------------------------------------------------------------------
package hsl_pkg;

    // input and output field widths
    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int CH_W  = 8;

    // clamp limits
    localparam logic [HUE_W-1:0] HUE_MAX = 9'd359;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [PCT_W-1:0] LIT_HALF = 7'd50;

    // levels in units of 1/10000, up to 10000
    localparam int LVL_W = 14;
    // ramp position 0..60
    localparam int RAMP_W = 6;
    // level * 60, up to 600000
    localparam int NUM_W = 20;

    // floor(num * 255 / 600000) = floor(num * 17 / 40000)
    // done as (num * 17 * ceil(2^36 / 40000)) >> 36, exact over the num range
    localparam int                 Q_SHIFT = 36;
    localparam int                 PROD_W  = 45;
    localparam logic [PROD_W-1:0]  RECIP17 = 45'd29205779;

    // channel select
    typedef enum logic [1:0] {
        CHAN_RED,
        CHAN_GREEN,
        CHAN_BLUE
    } t_chan;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // channel hue offset, single wrap into 0..360, then ramp position 0..60
    function automatic logic [RAMP_W-1:0] hue_ramp(input logic [HUE_W-1:0] hue,
                                                   input t_chan chan);
        logic [HUE_W:0] hv;
        logic [HUE_W:0] hw;
        logic [RAMP_W-1:0] t;
        hv = {1'b0, hue};
        unique case (chan)
            CHAN_RED: begin
                hw = hv + 10'd120;
                if (hw > 10'd360) begin
                    hw = hw - 10'd360;
                end
            end
            CHAN_BLUE: begin
                if (hv < 10'd120) begin
                    hw = hv + 10'd240;
                end else begin
                    hw = hv - 10'd120;
                end
            end
            default: begin
                hw = hv;
            end
        endcase
        if (hw < 10'd60) begin
            t = hw[RAMP_W-1:0];
        end else if (hw < 10'd180) begin
            t = 6'd60;
        end else if (hw < 10'd240) begin
            t = 6'(10'd240 - hw);
        end else begin
            t = '0;
        end
        return t;
    endfunction

endpackage

// ===== hw/rtl/hsl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_if: stream channels of the hsl to rgb converter
// One valid/ready channel carrying an hsl beat, one carrying an rgb beat.
// ----------------------------------------------------------------------------
interface hsl_in_if;
    logic                         valid;
    logic                         ready;
    logic [hsl_pkg::HUE_W-1:0]    hue;
    logic [hsl_pkg::PCT_W-1:0]    saturation;
    logic [hsl_pkg::PCT_W-1:0]    lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface hsl_out_if;
    logic                         valid;
    logic                         ready;
    logic [hsl_pkg::CH_W-1:0]     red;
    logic [hsl_pkg::CH_W-1:0]     green;
    logic [hsl_pkg::CH_W-1:0]     blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter: hsl pixel to 8-bit rgb
// Four-stage pipeline converting hue/saturation/lightness to red/green/blue.
// ----------------------------------------------------------------------------
// Takes one hsl beat per clock and gives one rgb beat per clock while the output
// is not stalled. A beat accepted into stage 1 passes stages 2 and 3 and is
// presented from the stage 4 register, leaving when the output is ready. Each
// pipeline stage holds its beat only while the stage after it is full and
// stalled, so bubbles close up and the input stays ready as long as any stage
// can move. Inputs above range are clamped (hue to 359, percentages to 100).
// Stages: clamp and lightness times saturation; upper/lower level and hue ramp
// position; ramp level times 60 per channel; reciprocal multiply to 0..255 per
// channel, the last being the output register. The four register stages are one
// per step of dependent arithmetic; every stage loads each cycle unless stalled.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsl_in_if.sink      i_hsl,
    hsl_out_if.source   o_rgb
);

    hsl_pkg::t_pipe_en en;

    logic r_v1, r_v2, r_v3, r_v4;

    logic [hsl_pkg::HUE_W-1:0] n_s1_hue, r_s1_hue;
    logic [hsl_pkg::PCT_W-1:0] n_s1_sat, r_s1_sat;
    logic [hsl_pkg::PCT_W-1:0] n_s1_lit, r_s1_lit;
    logic [hsl_pkg::LVL_W-1:0] n_s1_ls,  r_s1_ls;

    logic [hsl_pkg::LVL_W-1:0] w_ll, w_sl, w_m2;
    logic [hsl_pkg::LVL_W-1:0] n_s2_m1, r_s2_m1;
    logic [hsl_pkg::LVL_W-1:0] n_s2_d,  r_s2_d;

    // stage enables: a stage loads when empty or when its beat moves on
    always_comb begin
        en.s4 = !r_v4 || o_rgb.ready;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign i_hsl.ready = en.s1;

    // valid bits travel with the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_hsl.valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    // stage 1: clamp and lightness times saturation
    always_comb begin
        n_s1_hue = (i_hsl.hue > hsl_pkg::HUE_MAX) ? hsl_pkg::HUE_MAX : i_hsl.hue;
        n_s1_sat = (i_hsl.saturation > hsl_pkg::PCT_MAX) ? hsl_pkg::PCT_MAX
                                                         : i_hsl.saturation;
        n_s1_lit = (i_hsl.lightness > hsl_pkg::PCT_MAX) ? hsl_pkg::PCT_MAX
                                                        : i_hsl.lightness;
        n_s1_ls  = hsl_pkg::LVL_W'(n_s1_lit) * hsl_pkg::LVL_W'(n_s1_sat);
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_s1_hue <= n_s1_hue;
            r_s1_sat <= n_s1_sat;
            r_s1_lit <= n_s1_lit;
            r_s1_ls  <= n_s1_ls;
        end
    end

    // stage 2: upper level with the split at half lightness, lower level, span
    always_comb begin
        w_ll = hsl_pkg::LVL_W'(r_s1_lit) * 14'd100;
        w_sl = hsl_pkg::LVL_W'(r_s1_sat) * 14'd100;
        if (r_s1_lit <= hsl_pkg::LIT_HALF) begin
            w_m2 = w_ll + r_s1_ls;
        end else begin
            w_m2 = w_ll + w_sl - r_s1_ls;
        end
        n_s2_m1 = (w_ll << 1) - w_m2;
        n_s2_d  = w_m2 - n_s2_m1;
    end

    always_ff @(posedge i_clk) begin
        if (en.s2) begin
            r_s2_m1 <= n_s2_m1;
            r_s2_d  <= n_s2_d;
        end
    end

    // stages 2 to 4 per channel
    hsl_channel u_red (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_chan  (hsl_pkg::CHAN_RED),
        .i_hue   (r_s1_hue),
        .i_m1    (r_s2_m1),
        .i_d     (r_s2_d),
        .o_level (o_rgb.red)
    );

    hsl_channel u_green (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_chan  (hsl_pkg::CHAN_GREEN),
        .i_hue   (r_s1_hue),
        .i_m1    (r_s2_m1),
        .i_d     (r_s2_d),
        .o_level (o_rgb.green)
    );

    hsl_channel u_blue (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_chan  (hsl_pkg::CHAN_BLUE),
        .i_hue   (r_s1_hue),
        .i_m1    (r_s2_m1),
        .i_d     (r_s2_d),
        .o_level (o_rgb.blue)
    );

    assign o_rgb.valid = r_v4;

endmodule

// ===== hw/rtl/hsl_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_channel: one color channel of the converter
// Hue ramp position (stage 2), ramp level times 60 (stage 3) and the
// scale to 0..255 by reciprocal multiply (stage 4).
// ----------------------------------------------------------------------------
module hsl_channel (
    input  logic                          i_clk,
    input  hsl_pkg::t_pipe_en             i_en,
    input  hsl_pkg::t_chan                i_chan,
    input  logic [hsl_pkg::HUE_W-1:0]     i_hue,
    input  logic [hsl_pkg::LVL_W-1:0]     i_m1,
    input  logic [hsl_pkg::LVL_W-1:0]     i_d,
    output logic [hsl_pkg::CH_W-1:0]      o_level
);

    logic [hsl_pkg::RAMP_W-1:0] r_t;
    logic [hsl_pkg::RAMP_W-1:0] n_t;
    logic [hsl_pkg::NUM_W-1:0]  r_num;
    logic [hsl_pkg::NUM_W-1:0]  n_num;
    logic [hsl_pkg::CH_W-1:0]   r_level;
    logic [hsl_pkg::PROD_W-1:0] w_prod;

    // stage 2: wrapped hue to ramp position
    assign n_t = hsl_pkg::hue_ramp(i_hue, i_chan);

    // stage 3: m1*60 + (m2-m1)*t, never negative
    assign n_num = hsl_pkg::NUM_W'(i_m1) * 20'd60
                 + hsl_pkg::NUM_W'(i_d) * hsl_pkg::NUM_W'(r_t);

    // stage 4: floor(num*255/600000) by reciprocal multiply
    assign w_prod = hsl_pkg::PROD_W'(r_num) * hsl_pkg::RECIP17;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_t <= n_t;
        end
        if (i_en.s3) begin
            r_num <= n_num;
        end
        if (i_en.s4) begin
            r_level <= w_prod[hsl_pkg::Q_SHIFT +: hsl_pkg::CH_W];
        end
    end

    assign o_level = r_level;

endmodule

// ===== hw/rtl/hsl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_checker: port-level checks of the hsl to rgb converter
// Reset behavior, pipeline fill time, ready under free flow, stall hold.
// ----------------------------------------------------------------------------
module hsl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [hsl_pkg::CH_W-1:0]     i_red,
    input logic [hsl_pkg::CH_W-1:0]     i_green,
    input logic [hsl_pkg::CH_W-1:0]     i_blue
);

    // no output beat in the cycle after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a beat needs four stages to reach the output after reset
    a_fill_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_rst_n, 1) || !$past(i_rst_n, 2) || !$past(i_rst_n, 3))
        |-> !i_out_valid)
        else $error("output beat earlier than pipeline depth");

    // an empty or draining output stage never blocks the input
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while pipeline can move");

    // a stalled output beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("stalled output beat changed");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_hsl.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);
